// File: src/bot_pkg.sv
package bot_pkg;

  localparam int MaxCdbBytes = 16;
  localparam int WrapLen = 31;
  localparam logic [31:0] CmdSig = 32'h4342_5355;
  localparam logic [31:0] StsSig = 32'h5342_5355;
  localparam logic [3:0] StatusLen = 4'd13;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_DONE  = 2'd2,
    CMD_CSW   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_WRAP    = 2'd0,
    KIND_UNSTALL = 2'd1,
    KIND_DONE    = 2'd2
  } kind_t;

  localparam logic [1:0] CS_HARD = 2'd2;
  localparam logic [1:0] REC_NONE = 2'd0;
  localparam logic [1:0] REC_RESET = 2'd1;
  localparam logic [1:0] REC_DETACH = 2'd2;

  localparam logic REG_WRONG_RES = 1'b0;
  localparam logic REG_ERR_LIMIT = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic take_start;  // latch start fields
    logic take_byte;   // store command byte
    logic take_done;   // record moved count
    logic csw_retry;   // mark status retried
    logic csw_fail;    // failure completion
    logic csw_good;    // good/check completion
    logic wrap_begin;  // bump tag, clear byte index
    logic wrap_step;   // advance byte index
  } bot_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       start_zero;   // start item with zero command length
    logic       byte_ok;      // a command byte is awaited
    logic       byte_final;   // this byte completes the command
    logic       pend_zero;    // pending length is zero
    logic       unstall_in;   // data-done asks for unstall
    logic       csw_stall;    // first stall of this transaction
    logic       csw_bad;      // status wrapper check fails
    logic       wrap_end;     // index at last wrapper byte
  } bot_sts_t;

endpackage

// File: src/bot_datapath.sv
module bot_datapath #(
  parameter int MAX_CDB_BYTES = bot_pkg::MaxCdbBytes
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [3:0]           lun,
  input  logic                 data_out,
  input  logic [31:0]          data_length,
  input  logic [4:0]           cdb_length,
  input  logic [7:0]           cdb_byte,
  input  logic signed [32:0]   transferred,
  input  logic [3:0]           csw_length,
  input  logic [31:0]          csw_signature,
  input  logic [31:0]          csw_tag,
  input  logic [31:0]          csw_residue,
  input  logic [7:0]           csw_status,
  input  logic                 cfg_wrong_res,
  input  logic [7:0]           cfg_err_limit,
  input  bot_pkg::bot_cmd_t    ctl,
  output bot_pkg::bot_sts_t    sts,
  output logic [7:0]           wrap_byte,
  output logic [1:0]           done_status,
  output logic [31:0]          done_count,
  output logic [1:0]           done_rec
);

  localparam int IdxW = $clog2(bot_pkg::WrapLen);

  logic [31:0]        command_tag;
  logic [7:0]         error_count;
  logic [3:0]         pending_lun;
  logic               pending_direction;
  logic [31:0]        pending_length;
  logic [7:0]         command_bytes [16];
  logic [4:0]         bytes_expected;
  logic [4:0]         bytes_received;
  logic signed [33:0] moved_count;
  logic               status_retried;
  logic [IdxW-1:0]    wrap_idx;

  logic [4:0]         n_sat;
  logic signed [34:0] residue;
  logic signed [34:0] bc;
  logic [4:0]         rcv_inc;
  logic [3:0]         cb_idx;

  assign n_sat   = (cdb_length > 5'(MAX_CDB_BYTES)) ? 5'(MAX_CDB_BYTES) : cdb_length;
  assign rcv_inc = bytes_received + 5'd1;

  assign sts.start_zero = (n_sat == 5'd0);
  assign sts.byte_ok    = (bytes_received < bytes_expected) && (bytes_received < 5'd16);
  assign sts.byte_final = (rcv_inc == bytes_expected);
  assign sts.pend_zero  = (pending_length == 32'd0);
  assign sts.unstall_in = ((transferred[32]) || (transferred == 33'sd0)) && !pending_direction;
  assign sts.csw_stall  = (csw_length == 4'd0) && !status_retried;
  assign sts.csw_bad    = (csw_length != bot_pkg::StatusLen) || (csw_signature != bot_pkg::StsSig)
                          || (csw_tag != command_tag) || (csw_status >= 8'd2);
  assign sts.wrap_end   = (wrap_idx == IdxW'(bot_pkg::WrapLen - 1));

  always_comb begin
    residue = {3'b000, csw_residue};
    if (csw_residue == 32'd0 || cfg_wrong_res) begin
      residue = 35'({1'b0, pending_length}) - 35'(moved_count);
    end
    bc = 35'({1'b0, pending_length}) - residue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_tag       <= '0;
      error_count       <= '0;
      pending_lun       <= '0;
      pending_direction <= 1'b0;
      pending_length    <= '0;
      bytes_expected    <= '0;
      bytes_received    <= '0;
      moved_count       <= '0;
      status_retried    <= 1'b0;
      wrap_idx          <= '0;
      done_status       <= '0;
      done_count        <= '0;
      done_rec          <= '0;
      for (int i = 0; i < 16; i++) command_bytes[i] <= '0;
    end else begin
      if (ctl.take_start) begin
        pending_lun       <= lun;
        pending_direction <= data_out;
        pending_length    <= data_length;
        bytes_expected    <= n_sat;
        bytes_received    <= '0;
        moved_count       <= 34'({1'b0, data_length});
        status_retried    <= 1'b0;
      end
      if (ctl.take_byte) begin
        command_bytes[bytes_received[3:0]] <= cdb_byte;
        bytes_received <= rcv_inc;
      end
      if (ctl.take_done) moved_count <= 34'(transferred);
      if (ctl.csw_retry) status_retried <= 1'b1;
      if (ctl.csw_fail) begin
        done_status    <= bot_pkg::CS_HARD;
        done_count     <= '0;
        done_rec       <= (error_count > cfg_err_limit) ? bot_pkg::REC_DETACH
                                                         : bot_pkg::REC_RESET;
        if (error_count != 8'hff) error_count <= error_count + 8'd1;
        status_retried <= 1'b0;
      end
      if (ctl.csw_good) begin
        done_status <= csw_status[1:0];
        if (bc < 0) done_count <= '0;
        else if (bc > 35'sh0_FFFF_FFFF) done_count <= '1;
        else done_count <= bc[31:0];
        done_rec       <= bot_pkg::REC_NONE;
        error_count    <= '0;
        status_retried <= 1'b0;
      end
      if (ctl.wrap_begin) begin
        command_tag <= command_tag + 32'd1;
        wrap_idx    <= '0;
      end else if (ctl.wrap_step) begin
        wrap_idx <= wrap_idx + IdxW'(1);
      end
    end
  end

  // wrapper byte select from index
  assign cb_idx = 4'(wrap_idx - IdxW'(15));
  always_comb begin
    wrap_byte = 8'h00;
    if (wrap_idx < IdxW'(4))       wrap_byte = bot_pkg::CmdSig[8*wrap_idx[1:0] +: 8];
    else if (wrap_idx < IdxW'(8))  wrap_byte = command_tag[8*wrap_idx[1:0] +: 8];
    else if (wrap_idx < IdxW'(12)) wrap_byte = pending_length[8*wrap_idx[1:0] +: 8];
    else if (wrap_idx == IdxW'(12)) wrap_byte = pending_direction ? 8'h00 : 8'h80;
    else if (wrap_idx == IdxW'(13)) wrap_byte = {4'h0, pending_lun};
    else if (wrap_idx == IdxW'(14)) wrap_byte = {3'b000, bytes_expected};
    else if (5'(cb_idx) < bytes_expected) wrap_byte = command_bytes[cb_idx];
  end

endmodule

// File: src/bot_control.sv
module bot_control (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic              out_last,
  output bot_pkg::bot_cmd_t ctl,
  input  bot_pkg::bot_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_WRAP    = 4'b0010,
    S_UNSTALL = 4'b0100,
    S_DONE    = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   acc;

  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign out_valid = (state != S_IDLE);

  always_comb begin
    unique case (state)
      S_WRAP:    out_kind = bot_pkg::KIND_WRAP;
      S_UNSTALL: out_kind = bot_pkg::KIND_UNSTALL;
      S_DONE:    out_kind = bot_pkg::KIND_DONE;
      default:   out_kind = bot_pkg::KIND_WRAP;
    endcase
  end
  assign out_last = (state == S_WRAP) && sts.wrap_end;

  always_comb begin
    ctl = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          unique case (bot_pkg::cmd_t'(cmd))
            bot_pkg::CMD_START: begin
              ctl.take_start = 1'b1;
              if (sts.start_zero) begin
                ctl.wrap_begin = 1'b1;
                state_next = S_WRAP;
              end
            end
            bot_pkg::CMD_BYTE: begin
              if (sts.byte_ok) begin
                ctl.take_byte = 1'b1;
                if (sts.byte_final) begin
                  ctl.wrap_begin = 1'b1;
                  state_next = S_WRAP;
                end
              end
            end
            bot_pkg::CMD_DONE: begin
              if (!sts.pend_zero) begin
                ctl.take_done = 1'b1;
                if (sts.unstall_in) state_next = S_UNSTALL;
              end
            end
            default: begin
              if (sts.csw_stall) begin
                ctl.csw_retry = 1'b1;
                state_next = S_UNSTALL;
              end else if (sts.csw_bad) begin
                ctl.csw_fail = 1'b1;
                state_next = S_DONE;
              end else begin
                ctl.csw_good = 1'b1;
                state_next = S_DONE;
              end
            end
          endcase
        end
      end
      S_WRAP: begin
        if (out_ready) begin
          ctl.wrap_step = 1'b1;
          if (sts.wrap_end) state_next = S_IDLE;
        end
      end
      default: if (out_ready) state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("input taken while busy");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> (state == S_IDLE)) else $error("run not closed");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.take_start, ctl.take_byte, ctl.take_done, ctl.csw_retry,
              ctl.csw_fail, ctl.csw_good})) else $error("conflicting commands");
`endif

endmodule

// File: src/bulk_only_transport_host.sv
// Host side of a USB bulk-only mass storage transaction. Items are taken one
// at a time: an item that gives no result leaves the block ready for the next
// item; an item that gives one result (unstall request or completion) holds
// off new input until out_ready takes the result; the final command byte (or
// a zero-length start) produces the 31-byte command wrapper, one byte per
// cycle that out_ready is high, with no new input taken until the last byte
// leaves. Configuration is written through cfg_we/cfg_index/cfg_data: index
// 0 wrong_residues, 1 error_limit.
module bulk_only_transport_host #(
  parameter int MAX_CDB_BYTES = bot_pkg::MaxCdbBytes
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [3:0]         lun,
  input  logic               data_out,
  input  logic [31:0]        data_length,
  input  logic [4:0]         cdb_length,
  input  logic [7:0]         cdb_byte,
  input  logic signed [32:0] transferred,
  input  logic [3:0]         csw_length,
  input  logic [31:0]        csw_signature,
  input  logic [31:0]        csw_tag,
  input  logic [31:0]        csw_residue,
  input  logic [7:0]         csw_status,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         result_kind,
  output logic [7:0]         wrapper_byte,
  output logic               last,
  output logic [1:0]         completion_status,
  output logic [31:0]        byte_count,
  output logic [1:0]         recovery
);

  logic              wrong_residues;
  logic [7:0]        error_limit;
  bot_pkg::bot_cmd_t ctl;
  bot_pkg::bot_sts_t sts;
  logic [7:0]        wb;
  logic [1:0]        dst;
  logic [31:0]       dcnt;
  logic [1:0]        drec;
  logic [1:0]        kind;
  logic              is_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrong_residues <= 1'b0;
      error_limit    <= 8'd15;
    end else if (cfg_we) begin
      if (cfg_index == bot_pkg::REG_WRONG_RES) wrong_residues <= cfg_data[0];
      else error_limit <= cfg_data;
    end
  end

  bot_control u_ctl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(kind), .out_last(last),
    .ctl(ctl), .sts(sts)
  );

  bot_datapath #(.MAX_CDB_BYTES(MAX_CDB_BYTES)) u_dp (
    .clk(clk), .rst(rst), .lun(lun), .data_out(data_out),
    .data_length(data_length), .cdb_length(cdb_length), .cdb_byte(cdb_byte),
    .transferred(transferred), .csw_length(csw_length), .csw_signature(csw_signature),
    .csw_tag(csw_tag), .csw_residue(csw_residue), .csw_status(csw_status),
    .cfg_wrong_res(wrong_residues), .cfg_err_limit(error_limit),
    .ctl(ctl), .sts(sts), .wrap_byte(wb), .done_status(dst), .done_count(dcnt),
    .done_rec(drec)
  );

  assign is_done           = (kind == bot_pkg::KIND_DONE);
  assign result_kind       = kind;
  assign wrapper_byte      = (kind == bot_pkg::KIND_WRAP) ? wb : 8'h00;
  assign completion_status = is_done ? dst : 2'd0;
  assign byte_count        = is_done ? dcnt : 32'd0;
  assign recovery          = is_done ? drec : bot_pkg::REC_NONE;

endmodule
